// ===== design/dcpb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcpb_pkg
// Shared types, opcodes and helpers for the DMA copy program builder.
// ----------------------------------------------------------------------------
package dcpb_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 22;
  localparam int IDX_W  = 5;
  localparam int PLEN_W = 8;

  localparam logic [7:0] OP_MOV   = 8'hbc;
  localparam logic [7:0] OP_LD    = 8'h04;
  localparam logic [7:0] OP_RMB   = 8'h12;
  localparam logic [7:0] OP_ST    = 8'h08;
  localparam logic [7:0] OP_WMB   = 8'h13;
  localparam logic [7:0] OP_LP    = 8'h20;
  localparam logic [7:0] OP_LPEND = 8'h28;
  localparam logic [7:0] OP_END   = 8'h00;

  localparam logic [7:0] REG_SAR = 8'd0;
  localparam logic [7:0] REG_CCR = 8'd1;
  localparam logic [7:0] REG_DAR = 8'd2;

  localparam logic [31:0] CC_SRC_NS  = 32'h0000_0200;
  localparam logic [31:0] CC_DST_NS  = 32'h0080_0000;
  localparam logic [31:0] CC_DST_INC = 32'h0000_4000;

  localparam logic [7:0] JUMP_INNER = 8'd4;
  localparam logic [7:0] JUMP_OUTER = 8'd8;

  // cfg register indexes
  localparam logic CFG_DEVICE_READY = 1'b0;
  localparam logic CFG_NONSECURE    = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_INVALID   = 2'd2,
    STAT_TOO_BIG   = 2'd3
  } status_e;

  // one instruction, bytes in program order from the lowest byte up
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [2:0]  nbytes;
    logic [47:0] bytes;
  } push_t;

  typedef struct packed {
    logic              err_valid;
    status_e           status;
    logic [PLEN_W-1:0] plen;
  } seq_stat_t;

  function automatic logic [31:0] ctrl_word(input logic [1:0] beats_m1, input logic ns);
    logic [31:0] c;
    c = 32'd1 | CC_DST_INC | (32'd2 << 1) | (32'd2 << 15) |
        (32'(beats_m1) << 4) | (32'(beats_m1) << 18);
    if (ns) begin
      c = c | CC_SRC_NS | CC_DST_NS;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/dcpb_pack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcpb_pack
// Byte packer: merges instructions of 1..6 bytes into 32-bit program words.
// ----------------------------------------------------------------------------
module dcpb_pack
  import dcpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  push_t       push_i,
  output logic        push_ready_o,
  input  logic        pop_i,
  output logic        avail_o,
  output logic [31:0] word_o,
  output logic        last_o
);

  localparam int CAP_BYTES = 12;
  localparam int CNT_W     = 4;

  logic [CAP_BYTES*8-1:0] buf_q, buf_d, buf_mid;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_mid;
  logic                   last_q, last_d;
  logic                   do_pop, do_push;

  assign avail_o      = (cnt_q >= CNT_W'(4)) || (last_q && (cnt_q != '0));
  assign last_o       = last_q && (cnt_q <= CNT_W'(4));
  assign word_o       = buf_q[31:0];
  assign push_ready_o = (cnt_q <= CNT_W'(6)) && !last_q;
  assign do_pop       = pop_i && avail_o;
  assign do_push      = push_i.valid && push_ready_o;

  always_comb begin
    buf_mid = buf_q;
    cnt_mid = cnt_q;
    last_d  = last_q;
    if (do_pop) begin
      buf_mid = buf_q >> 32;
      cnt_mid = last_o ? '0 : cnt_q - CNT_W'(4);
      if (last_o) begin
        last_d = 1'b0;
      end
    end
    buf_d = buf_mid;
    cnt_d = cnt_mid;
    if (do_push) begin
      buf_d = buf_mid | ((CAP_BYTES*8)'(push_i.bytes) << {cnt_mid, 3'b000});
      cnt_d = cnt_mid + CNT_W'(push_i.nbytes);
      last_d = push_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAP_BYTES))
    else $error("packer overfilled");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && last_o) |=> (cnt_q == '0) && !last_q)
    else $error("packer not empty after last word");
`endif

endmodule
`default_nettype wire

// ===== design/dcpb_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcpb_seq
// Request checker and instruction sequencer: one instruction per step.
// ----------------------------------------------------------------------------
module dcpb_seq
  import dcpb_pkg::*;
#(
  parameter int PROGRAM_BYTES  = 128,
  parameter int MAX_COPY_BYTES = 1048576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [ADDR_W-1:0] dst_i,
  input  logic [ADDR_W-1:0] src_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic              device_ready_i,
  input  logic              nonsecure_i,
  output push_t             push_o,
  input  logic              push_ready_i,
  output seq_stat_t         stat_o,
  input  logic              err_ack_i,
  input  logic              done_i
);

  localparam int TOT_W = $clog2(PROGRAM_BYTES + 1);
  localparam int BUR_W = LEN_W - 4;

  typedef enum logic [4:0] {
    S_IDLE, S_CALC, S_MOVCCR, S_MOVSAR, S_MOVDAR, S_OLP, S_ILP, S_OBODY, S_ILPE,
    S_OLPE, S_RLP, S_RBODY, S_RLPE, S_TMOV, S_TBODY, S_END, S_ERR, S_DRAIN
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] dst_q, src_q;
  logic [LEN_W-1:0]  len_q;
  status_e           status_q;
  logic [PLEN_W-1:0] plen_q;
  logic [8:0]        rem_q;
  logic [1:0]        rest_q;
  logic [7:0]        outer_m1_q;

  logic [BUR_W-1:0]  bursts;
  logic [BUR_W-9:0]  outer;
  logic              big;
  logic [8:0]        rem;
  logic [1:0]        rest;
  logic [TOT_W-1:0]  total;
  logic              too_big;
  logic              bad_req;
  state_e            tail_next, rem_next;

  assign bursts = len_q[LEN_W-1:4];
  assign rest   = len_q[3:2];
  assign outer  = bursts[BUR_W-1:8];
  assign big    = bursts > BUR_W'(256);
  assign rem    = big ? {1'b0, bursts[7:0]} : bursts[8:0];

  always_comb begin
    total = TOT_W'(18);
    if (big) begin
      total = total + TOT_W'(12);
    end
    if (rem == 9'd1) begin
      total = total + TOT_W'(4);
    end else if (rem > 9'd1) begin
      total = total + TOT_W'(8);
    end
    if (rest != 2'd0) begin
      total = total + TOT_W'(6) + TOT_W'({rest, 2'b00});
    end
  end

  assign too_big = (big && (outer > (BUR_W-8)'(256))) || (total >= TOT_W'(PROGRAM_BYTES));
  assign bad_req = (dst_i == '0) || (src_i == '0) || (len_i == '0) ||
                   ({1'b0, len_i} > (LEN_W+1)'(MAX_COPY_BYTES)) ||
                   (dst_i[1:0] != 2'b00) || (src_i[1:0] != 2'b00) ||
                   (len_i[1:0] != 2'b00);

  assign tail_next = (rest_q != 2'd0) ? S_TMOV : S_END;
  always_comb begin
    if (rem_q == 9'd1) begin
      rem_next = S_RBODY;
    end else if (rem_q > 9'd1) begin
      rem_next = S_RLP;
    end else begin
      rem_next = tail_next;
    end
  end

  assign req_ready_o      = (state_q == S_IDLE);
  assign stat_o.err_valid = (state_q == S_ERR);
  assign stat_o.status    = status_q;
  assign stat_o.plen      = plen_q;

  always_comb begin
    push_o.valid  = 1'b1;
    push_o.last   = 1'b0;
    push_o.nbytes = 3'd2;
    push_o.bytes  = '0;
    unique case (state_q)
      S_MOVCCR: begin
        push_o.nbytes = 3'd6;
        push_o.bytes  = {ctrl_word(2'd3, nonsecure_i), REG_CCR, OP_MOV};
      end
      S_MOVSAR: begin
        push_o.nbytes = 3'd6;
        push_o.bytes  = {src_q, REG_SAR, OP_MOV};
      end
      S_MOVDAR: begin
        push_o.nbytes = 3'd6;
        push_o.bytes  = {dst_q, REG_DAR, OP_MOV};
      end
      S_TMOV: begin
        push_o.nbytes = 3'd6;
        push_o.bytes  = {ctrl_word(2'd0, nonsecure_i), REG_CCR, OP_MOV};
      end
      S_OBODY, S_RBODY, S_TBODY: begin
        push_o.nbytes = 3'd4;
        push_o.bytes  = {16'h0000, OP_WMB, OP_ST, OP_RMB, OP_LD};
      end
      S_OLP:  push_o.bytes = {32'h0, outer_m1_q, OP_LP};
      S_ILP:  push_o.bytes = {32'h0, 8'hff, OP_LP | 8'h02};
      S_RLP:  push_o.bytes = {32'h0, 8'(rem_q - 9'd1), OP_LP};
      S_ILPE: push_o.bytes = {32'h0, JUMP_INNER, OP_LPEND | 8'h10 | 8'h04};
      S_OLPE: push_o.bytes = {32'h0, JUMP_OUTER, OP_LPEND | 8'h10};
      S_RLPE: push_o.bytes = {32'h0, JUMP_INNER, OP_LPEND | 8'h10};
      S_END: begin
        push_o.nbytes = 3'd1;
        push_o.last   = 1'b1;
        push_o.bytes  = {40'h0, OP_END};
      end
      default: begin
        push_o.valid  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dst_q      <= '0;
      src_q      <= '0;
      len_q      <= '0;
      status_q   <= STAT_OK;
      plen_q     <= '0;
      rem_q      <= '0;
      rest_q     <= '0;
      outer_m1_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            dst_q <= dst_i;
            src_q <= src_i;
            len_q <= len_i;
            if (!device_ready_i) begin
              status_q <= STAT_NOT_READY;
            end else if (bad_req) begin
              status_q <= STAT_INVALID;
            end else begin
              status_q <= STAT_OK;
            end
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          rem_q      <= rem;
          rest_q     <= rest;
          outer_m1_q <= 8'(outer - (BUR_W-8)'(1));
          plen_q     <= PLEN_W'(total + TOT_W'(1));
          if (status_q != STAT_OK) begin
            state_q <= S_ERR;
          end else if (too_big) begin
            status_q <= STAT_TOO_BIG;
            state_q  <= S_ERR;
          end else begin
            state_q <= S_MOVCCR;
          end
        end
        S_ERR: begin
          if (err_ack_i) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          if (push_ready_i) begin
            priority case (state_q)
              S_MOVCCR: state_q <= S_MOVSAR;
              S_MOVSAR: state_q <= S_MOVDAR;
              S_MOVDAR: state_q <= big ? S_OLP : rem_next;
              S_OLP:    state_q <= S_ILP;
              S_ILP:    state_q <= S_OBODY;
              S_OBODY:  state_q <= S_ILPE;
              S_ILPE:   state_q <= S_OLPE;
              S_OLPE:   state_q <= rem_next;
              S_RLP:    state_q <= S_RBODY;
              S_RBODY:  state_q <= (rem_q > 9'd1) ? S_RLPE : tail_next;
              S_RLPE:   state_q <= tail_next;
              S_TMOV:   state_q <= S_TBODY;
              S_TBODY: begin
                rest_q <= rest_q - 2'd1;
                if (rest_q == 2'd1) begin
                  state_q <= S_END;
                end
              end
              S_END:    state_q <= S_DRAIN;
              default:  state_q <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/dma_copy_program_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dma_copy_program_builder
// Turns one copy request into a DMA channel program, one word per result.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one copy request (destination, source, length).
//   Master stream returns the program as 32-bit little-endian words with
//   their index, the total program length and a status; tlast marks the
//   final word. A rejected request gives a single zero word with its status.
//   cfg_we_i writes device_ready (index 0) or manager_nonsecure (index 1), bit 0 of
//   the data only; the user must write only while no request is in flight (not enforced).
// Timing:
//   One request at a time; s_axis_tready_o is low until the last word has
//   been taken. The sequencer issues one instruction per cycle into a 12-byte
//   packer while it has room; the packer sets the pace. A request is first
//   registered and checked; its words then pass through the packer and the
//   output register, up to one word per cycle while the receiver is ready.
//   A rejected request gives its result from an error state instead.
// Reset clears the control registers and empties the packer and output register.
// A stalled receiver holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module dma_copy_program_builder
  import dcpb_pkg::*;
#(
  parameter int PROGRAM_BYTES  = 128,
  parameter int MAX_COPY_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // dst_addr[31:0], src_addr[63:32], copy_length[85:64]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // prog_word[31:0], word_index[36:32],
                                       // program_length[44:37], status[46:45]
  output logic        m_axis_tlast_o,  // last_word
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic        cfg_wdata_i
);

  logic              dev_ready_q, nonsecure_q;
  push_t             push;
  logic              push_ready;
  seq_stat_t         stat;
  logic              pk_avail, pk_last, pk_pop;
  logic [31:0]       pk_word;
  logic              slot_free, err_ack, done;

  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic [IDX_W-1:0]  out_idx_q, idx_q;
  logic [PLEN_W-1:0] out_plen_q;
  logic [1:0]        out_stat_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_ready_q <= 1'b0;
      nonsecure_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DEVICE_READY: dev_ready_q <= cfg_wdata_i;
        CFG_NONSECURE:    nonsecure_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  dcpb_seq #(
    .PROGRAM_BYTES (PROGRAM_BYTES),
    .MAX_COPY_BYTES(MAX_COPY_BYTES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid_i),
    .req_ready_o   (s_axis_tready_o),
    .dst_i         (s_axis_tdata_i[31:0]),
    .src_i         (s_axis_tdata_i[63:32]),
    .len_i         (s_axis_tdata_i[85:64]),
    .device_ready_i(dev_ready_q),
    .nonsecure_i   (nonsecure_q),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .stat_o        (stat),
    .err_ack_i     (err_ack),
    .done_i        (done)
  );

  dcpb_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .pop_i       (slot_free),
    .avail_o     (pk_avail),
    .word_o      (pk_word),
    .last_o      (pk_last)
  );

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign pk_pop    = pk_avail && slot_free;
  assign err_ack   = stat.err_valid && slot_free;
  assign done      = out_valid_q && m_axis_tready_i && out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (pk_pop) begin
        out_valid_q <= 1'b1;
        idx_q       <= pk_last ? '0 : idx_q + IDX_W'(1);
      end else if (err_ack) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pk_pop) begin
      out_word_q <= pk_word;
      out_idx_q  <= idx_q;
      out_plen_q <= stat.plen;
      out_stat_q <= 2'(STAT_OK);
      out_last_q <= pk_last;
    end else if (err_ack) begin
      out_word_q <= '0;
      out_idx_q  <= '0;
      out_plen_q <= '0;
      out_stat_q <= 2'(stat.status);
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_stat_q, out_plen_q, out_idx_q, out_word_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !out_valid_q)
    else $error("request taken while a result is pending");
`endif

endmodule
`default_nettype wire
